FILE: rtl/fnr_pkg.sv
// Shared types, constants and the saturating add for the forcing
// normalization reduction. No dependencies.
package fnr_pkg;

   localparam int AccWidth     = 48;
   localparam int DataWidth    = 16;
   localparam int NumWidth     = 46;
   localparam int DivSteps     = NumWidth;
   localparam int DivCntWidth  = $clog2(DivSteps);
   localparam int Lanes        = 3;
   localparam int LaneIdxWidth = $clog2(Lanes);

   localparam logic signed [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
   localparam logic signed [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};
   localparam logic [DataWidth-1:0] DensityTop = {DataWidth{1'b1}};

   typedef struct packed {
      logic [15:0]        density;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_z;
      logic signed [15:0] push_x;
      logic signed [15:0] push_y;
      logic signed [15:0] push_z;
      logic [15:0]        sound_speed_sq;
      logic               last_cell;
   } req_word_type;

   typedef struct packed {
      logic signed [47:0] sum_rho_v_f;
      logic [46:0]        sum_rho_f2;
      logic [46:0]        sum_rho_mach2;
      logic [46:0]        sum_mach2;
      logic [46:0]        sum_rho_v2;
      logic [46:0]        sum_v2;
      logic [46:0]        sum_rho2;
      logic [15:0]        min_density;
      logic [15:0]        max_density;
   } rsp_word_type;

   typedef struct packed {
      logic signed [AccWidth-1:0] rho_v_f;
      logic signed [AccWidth-1:0] rho_f2;
      logic signed [AccWidth-1:0] rho_mach2;
      logic signed [AccWidth-1:0] mach2;
      logic signed [AccWidth-1:0] rho_v2;
      logic signed [AccWidth-1:0] v2;
   } term_type;

   typedef struct packed {
      logic signed [AccWidth-1:0] rho_v_f;
      logic signed [AccWidth-1:0] rho_f2;
      logic signed [AccWidth-1:0] rho_mach2;
      logic signed [AccWidth-1:0] mach2;
      logic signed [AccWidth-1:0] rho_v2;
      logic signed [AccWidth-1:0] v2;
      logic signed [AccWidth-1:0] rho2;
      logic [DataWidth-1:0]       least;
      logic [DataWidth-1:0]       most;
   } acc_type;

   typedef struct packed {
      logic add_lane;
      logic add_cell;
      logic clear;
   } merge_ctl_type;

   function automatic logic signed [AccWidth-1:0] sat_add(
      input logic signed [AccWidth-1:0] a,
      input logic signed [AccWidth-1:0] b);
      logic signed [AccWidth:0] s;
      s = {a[AccWidth-1], a} + {b[AccWidth-1], b};
      if (s[AccWidth] != s[AccWidth-1]) begin
         sat_add = s[AccWidth] ? AccMin : AccMax;
      end else begin
         sat_add = s[AccWidth-1:0];
      end
   endfunction

endpackage

FILE: rtl/fnr_div.sv
// Restoring divider, one quotient bit per cycle; zero divisor saturates.
// Depends on fnr_pkg.
module fnr_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [fnr_pkg::NumWidth-1:0]       num,
   input  logic [fnr_pkg::DataWidth-1:0]      den,
   output logic                               busy,
   output logic signed [fnr_pkg::AccWidth-1:0] quo
);

   logic                                busy_ff, busy_in;
   logic [fnr_pkg::DivCntWidth-1:0]     cnt_ff, cnt_in;
   logic [fnr_pkg::NumWidth-1:0]        qn_ff, qn_in;
   logic [fnr_pkg::DataWidth-1:0]       rem_ff, rem_in;
   logic [fnr_pkg::DataWidth-1:0]       den_ff, den_in;
   logic [fnr_pkg::DataWidth:0]         rem_sh;
   logic [fnr_pkg::DataWidth:0]         rem_sub;
   logic                                ge;

   always_comb begin
      rem_sh  = {rem_ff, qn_ff[fnr_pkg::NumWidth-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      ge      = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      qn_in   = qn_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         qn_in   = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         qn_in  = {qn_ff[fnr_pkg::NumWidth-2:0], ge};
         rem_in = ge ? rem_sub[fnr_pkg::DataWidth-1:0] : rem_sh[fnr_pkg::DataWidth-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == fnr_pkg::DivCntWidth'(fnr_pkg::DivSteps - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      qn_ff  <= qn_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = (den_ff == '0) ? fnr_pkg::AccMax : fnr_pkg::AccWidth'(qn_ff);

endmodule

FILE: rtl/fnr_lane.sv
// One component lane: two product stages and two dividers for the Mach terms.
// Depends on fnr_pkg and fnr_div.
module fnr_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          div_start,
   input  logic [15:0]                   density,
   input  logic signed [15:0]            vel,
   input  logic signed [15:0]            push,
   input  logic [15:0]                   sound_speed_sq,
   output fnr_pkg::term_type             term,
   output logic                          busy
);

   logic signed [31:0] vv_ff, vf_ff, ff_ff;
   logic [15:0]        rho_ff;
   logic signed [47:0] p_vf_ff;
   logic [45:0]        p_vv_ff, p_ff_ff;
   logic [30:0]        vv2_ff;
   logic [46:0]        p_vv_full, p_ff_full;
   logic signed [48:0] p_vf_full;
   logic               busy_a, busy_b;
   logic signed [fnr_pkg::AccWidth-1:0] quo_a, quo_b;

   always_comb begin
      p_vf_full = $signed({1'b0, rho_ff}) * vf_ff;
      p_vv_full = rho_ff * vv_ff[30:0];
      p_ff_full = rho_ff * ff_ff[30:0];
   end

   always_ff @(posedge clock) begin
      vv_ff   <= vel * vel;
      vf_ff   <= vel * push;
      ff_ff   <= push * push;
      rho_ff  <= density;
      p_vf_ff <= p_vf_full[47:0];
      p_vv_ff <= p_vv_full[45:0];
      p_ff_ff <= p_ff_full[45:0];
      vv2_ff  <= vv_ff[30:0];
   end

   fnr_div u_div_rho (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (p_vv_ff),
      .den   (sound_speed_sq),
      .busy  (busy_a),
      .quo   (quo_a)
   );

   fnr_div u_div_mach (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (fnr_pkg::NumWidth'({vv2_ff, 8'h00})),
      .den   (sound_speed_sq),
      .busy  (busy_b),
      .quo   (quo_b)
   );

   always_comb begin
      term.rho_v_f   = fnr_pkg::AccWidth'(p_vf_ff >>> 8);
      term.rho_f2    = fnr_pkg::AccWidth'(p_ff_ff >> 8);
      term.rho_mach2 = quo_a;
      term.mach2     = quo_b;
      term.rho_v2    = fnr_pkg::AccWidth'(p_vv_ff >> 8);
      term.v2        = fnr_pkg::AccWidth'(vv2_ff);
   end

   assign busy = busy_a | busy_b;

endmodule

FILE: rtl/fnr_merge.sv
// Merging stage: saturating accumulators and density min/max.
// Depends on fnr_pkg.
module fnr_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  fnr_pkg::merge_ctl_type  ctl,
   input  fnr_pkg::term_type       term,
   input  logic [15:0]             density,
   output fnr_pkg::acc_type        acc
);

   fnr_pkg::acc_type acc_ff, acc_in;
   fnr_pkg::acc_type acc_clr;
   logic [31:0]      rho_sq;

   always_comb begin
      acc_clr       = '0;
      acc_clr.least = fnr_pkg::DensityTop;
      rho_sq = density * density;
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = acc_clr;
      end else if (ctl.add_lane) begin
         acc_in.rho_v_f   = fnr_pkg::sat_add(acc_ff.rho_v_f, term.rho_v_f);
         acc_in.rho_f2    = fnr_pkg::sat_add(acc_ff.rho_f2, term.rho_f2);
         acc_in.rho_mach2 = fnr_pkg::sat_add(acc_ff.rho_mach2, term.rho_mach2);
         acc_in.mach2     = fnr_pkg::sat_add(acc_ff.mach2, term.mach2);
         acc_in.rho_v2    = fnr_pkg::sat_add(acc_ff.rho_v2, term.rho_v2);
         acc_in.v2        = fnr_pkg::sat_add(acc_ff.v2, term.v2);
      end else if (ctl.add_cell) begin
         acc_in.rho2 = fnr_pkg::sat_add(acc_ff.rho2, fnr_pkg::AccWidth'(rho_sq));
         if (density < acc_ff.least) begin
            acc_in.least = density;
         end
         if (density > acc_ff.most) begin
            acc_in.most = density;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= acc_clr;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/forcing_normalization_reduction_top.sv
// Top level of the forcing normalization reduction: three lanes, merge, control.
// Depends on fnr_pkg, fnr_lane, fnr_merge.
//
//   channel | ports                          | direction
//   req     | req_valid req_stall req_word   | cell word in
//   rsp     | rsp_valid rsp_stall rsp_word   | grid sums out on last cell
//   csr     | csr_write csr_wdata            | active_dims register
//
// The 46-step serial dividers dominate the work on each cell; a last cell also passes the emit state.
// Reset is synchronous; active_dims returns to 3 and all sums clear.
// A held result does not block new cells; only the emit of the next one waits.
module forcing_normalization_reduction_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fnr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fnr_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write,
   input  logic [1:0]            csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PROD  = 3'd1;
   localparam logic [2:0] S_DGO   = 3'd2;
   localparam logic [2:0] S_DWAIT = 3'd3;
   localparam logic [2:0] S_ACC   = 3'd4;
   localparam logic [2:0] S_CELL  = 3'd5;
   localparam logic [2:0] S_EMIT  = 3'd6;

   logic [2:0]                          state_ff, state_in;
   logic [fnr_pkg::LaneIdxWidth-1:0]    idx_ff, idx_in;
   logic [1:0]                          dims_ff;
   fnr_pkg::req_word_type               word_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   fnr_pkg::rsp_word_type               rsp_word_ff;
   logic [fnr_pkg::Lanes-1:0]           lane_busy;
   fnr_pkg::term_type                   lane_term [fnr_pkg::Lanes];
   logic signed [15:0]                  lane_vel  [fnr_pkg::Lanes];
   logic signed [15:0]                  lane_push [fnr_pkg::Lanes];
   fnr_pkg::merge_ctl_type              mctl;
   fnr_pkg::acc_type                    acc;
   logic                                accept, emit_go;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign emit_go   = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign lane_vel[0]  = word_ff.vel_x;
   assign lane_vel[1]  = word_ff.vel_y;
   assign lane_vel[2]  = word_ff.vel_z;
   assign lane_push[0] = word_ff.push_x;
   assign lane_push[1] = word_ff.push_y;
   assign lane_push[2] = word_ff.push_z;

   for (genvar g = 0; g < fnr_pkg::Lanes; g++) begin : g_lane
      fnr_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .div_start      (state_ff == S_DGO),
         .density        (word_ff.density),
         .vel            (lane_vel[g]),
         .push           (lane_push[g]),
         .sound_speed_sq (word_ff.sound_speed_sq),
         .term           (lane_term[g]),
         .busy           (lane_busy[g])
      );
   end

   always_comb begin
      mctl.add_lane = (state_ff == S_ACC) && ({1'b0, idx_ff} < {1'b0, dims_ff});
      mctl.add_cell = state_ff == S_CELL;
      mctl.clear    = emit_go;
   end

   fnr_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mctl),
      .term    (lane_term[idx_ff]),
      .density (word_ff.density),
      .acc     (acc)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PROD;
               idx_in   = '0;
            end
         end
         S_PROD: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == fnr_pkg::LaneIdxWidth'(1)) begin
               state_in = S_DGO;
            end
         end
         S_DGO: begin
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            idx_in = '0;
            if (lane_busy == '0) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == fnr_pkg::LaneIdxWidth'(fnr_pkg::Lanes - 1)) begin
               state_in = S_CELL;
               idx_in   = '0;
            end
         end
         S_CELL: begin
            state_in = word_ff.last_cell ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         dims_ff      <= 2'd3;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            dims_ff <= csr_wdata;
         end
      end
      if (accept) begin
         word_ff <= req_word;
      end
      if (emit_go) begin
         rsp_word_ff.sum_rho_v_f   <= 48'(acc.rho_v_f);
         rsp_word_ff.sum_rho_f2    <= 47'(acc.rho_f2);
         rsp_word_ff.sum_rho_mach2 <= 47'(acc.rho_mach2);
         rsp_word_ff.sum_mach2     <= 47'(acc.mach2);
         rsp_word_ff.sum_rho_v2    <= 47'(acc.rho_v2);
         rsp_word_ff.sum_v2        <= 47'(acc.v2);
         rsp_word_ff.sum_rho2      <= 47'(acc.rho2);
         rsp_word_ff.min_density   <= acc.least;
         rsp_word_ff.max_density   <= acc.most;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DWAIT && !lane_busy[0] |-> lane_busy == '0)
      else $error("lanes out of step");
   a_rise_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("result without emit");
   a_clear_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> acc.least == fnr_pkg::DensityTop && acc.rho2 == '0)
      else $error("sums not cleared after emit");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |=> $stable(word_ff))
      else $error("cell word changed mid-work");
`endif

endmodule
